// File: rtl/ufmc_pkg.sv
// shared types and constants for the union-find maze carver
`default_nettype none
package ufmc_pkg;
    localparam int MAX_CELLS_DEF   = 4096;
    localparam int MAX_COLUMNS_DEF = 64;
    localparam int IDX_W  = 12;
    localparam int COL_W  = 7;
    localparam int CNT_W  = 13;
    localparam int RANK_W = 4;
    localparam int WALL_W = 4;
    localparam int DIR_W  = 3;

    localparam logic [0:0] REG_COLUMNS    = 1'b0;
    localparam logic [0:0] REG_CELL_COUNT = 1'b1;

    localparam logic [DIR_W-1:0] DIR_NONE  = 3'd0;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd1;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd2;
    localparam logic [DIR_W-1:0] DIR_UP    = 3'd3;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd4;

    localparam logic [WALL_W-1:0] W_TOP    = 4'b0001;
    localparam logic [WALL_W-1:0] W_RIGHT  = 4'b0010;
    localparam logic [WALL_W-1:0] W_BOTTOM = 4'b0100;
    localparam logic [WALL_W-1:0] W_LEFT   = 4'b1000;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_DIV,
        S_FA_RD, S_FA_WT, S_FA_CP, S_FA_CW,
        S_FB_RD, S_FB_WT, S_FB_CP, S_FB_CW,
        S_RK_RD, S_RK_WT, S_LINK,
        S_WA_RD, S_WA_WT, S_WB_RD, S_WB_WT, S_WR_WALL,
        S_OUT
    } t_state;
endpackage
`default_nettype wire

// File: rtl/union_find_maze_carver_top.sv
// kruskal maze carver: union-find by rank with path compression and wall store
// sequence: a bad index goes straight to the result; otherwise both indices are divided
//   by columns, one quotient bit per cycle, then each find walks the parent links to the
//   root and rewrites every link it walked; a merge adds a rank read and a link step
// throughput: one edge at a time; o_stall stays high until the result word is taken
// reset: a clearing pass over all MAX_CELLS cells runs after reset and before each new_maze word
`default_nettype none
module union_find_maze_carver_top #(
    parameter int MAX_CELLS   = ufmc_pkg::MAX_CELLS_DEF,
    parameter int MAX_COLUMNS = ufmc_pkg::MAX_COLUMNS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic                      i_cfg_index,
    input  wire logic [ufmc_pkg::CNT_W-1:0] i_cfg_data,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic [ufmc_pkg::IDX_W-1:0] i_cell_a,
    input  wire logic [ufmc_pkg::IDX_W-1:0] i_cell_b,
    input  wire logic                      i_new_maze,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic                           o_merged,
    output logic [ufmc_pkg::DIR_W-1:0]     o_direction,
    output logic [ufmc_pkg::WALL_W-1:0]    o_walls_a,
    output logic [ufmc_pkg::WALL_W-1:0]    o_walls_b,
    output logic                           o_bad_index
);
    import ufmc_pkg::*;

    localparam int AW = $clog2(MAX_CELLS);
    localparam int MW = (AW > IDX_W) ? AW : IDX_W;
    localparam int SW = $clog2(MAX_CELLS + 1);
    localparam int QW = IDX_W + 1;

    t_state r_state, n_state;
    logic [COL_W-1:0]  r_columns;
    logic [CNT_W-1:0]  r_cell_count;
    logic [AW-1:0]     r_clr;
    logic [IDX_W-1:0]  r_a, r_b;
    logic              r_newm;
    logic [AW-1:0]     r_ptr, r_ra, r_rb;
    logic [SW-1:0]     r_steps;
    logic [RANK_W-1:0] r_rank_a;
    logic [WALL_W-1:0] r_wa, r_wb;
    logic [DIR_W-1:0]  r_dir;
    logic              r_merged, r_bad;
    // shared restoring divider: quotient/remainder of a then of b
    logic [IDX_W-1:0]  r_quo;
    logic [COL_W:0]    r_rem;
    logic [3:0]        r_bit;
    logic              r_which;
    logic [IDX_W-1:0]  r_qa;
    logic [COL_W-1:0]  r_ma;

    // memories: parent, rank, walls, each single port
    logic          p_we, k_we, w_we;
    logic [AW-1:0] p_addr, k_addr, w_addr;
    logic [AW-1:0] p_wd, p_rd;
    logic [RANK_W-1:0] k_wd, k_rd;
    logic [WALL_W-1:0] w_wd, w_rd;

    ufmc_ram #(.WIDTH(AW), .DEPTH(MAX_CELLS)) u_parent (
        .i_clk(i_clk), .i_we(p_we), .i_addr(p_addr), .i_wdata(p_wd), .o_rdata(p_rd));
    ufmc_ram #(.WIDTH(RANK_W), .DEPTH(MAX_CELLS)) u_rank (
        .i_clk(i_clk), .i_we(k_we), .i_addr(k_addr), .i_wdata(k_wd), .o_rdata(k_rd));
    ufmc_ram #(.WIDTH(WALL_W), .DEPTH(MAX_CELLS)) u_wall (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr), .i_wdata(w_wd), .o_rdata(w_rd));

    logic [COL_W-1:0] cols_eff;
    logic [SW-1:0]    cnt_eff;
    always_comb begin
        cols_eff = r_columns;
        if (r_columns == '0) cols_eff = COL_W'(1);
        if (32'(r_columns) > MAX_COLUMNS) cols_eff = COL_W'(MAX_COLUMNS);
        if (32'(r_cell_count) > MAX_CELLS) cnt_eff = SW'(MAX_CELLS);
        else cnt_eff = SW'(r_cell_count);
    end

    logic [AW-1:0] a_addr, b_addr;
    assign a_addr = AW'(MW'(r_a));
    assign b_addr = AW'(MW'(r_b));

    // divider step
    logic [IDX_W-1:0] div_num;
    logic [COL_W:0]   trial;
    logic             dbit;
    logic [COL_W:0]   rem_next;
    logic [IDX_W-1:0] quo_next;
    logic [COL_W-1:0] col_next;
    assign div_num  = r_which ? r_b : r_a;
    assign trial    = {r_rem[COL_W-1:0], div_num[r_bit]};
    assign dbit     = trial >= {1'b0, cols_eff};
    assign rem_next = dbit ? trial - {1'b0, cols_eff} : trial;
    assign quo_next = {r_quo[IDX_W-2:0], dbit};
    assign col_next = rem_next[COL_W-1:0];

    // a word that asks for a clear is held until the pass is done and then taken
    logic pending_clear_item;
    assign pending_clear_item = r_newm;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:   if (32'(r_clr) == MAX_CELLS - 1) n_state = S_IDLE;
            S_IDLE:    if (i_valid) n_state = (i_new_maze && !pending_clear_item)
                                              ? S_CLEAR : S_CHECK;
            S_CHECK:   n_state = r_bad ? S_OUT : S_DIV;
            S_DIV:     if (r_bit == '0 && r_which) n_state = S_FA_RD;
            S_FA_RD:   n_state = S_FA_WT;
            S_FA_WT:   n_state = (p_rd == r_ptr || 32'(r_steps) >= MAX_CELLS)
                                 ? S_FA_CW : S_FA_RD;
            S_FA_CW:   n_state = S_FA_CP;
            S_FA_CP:   n_state = (r_ptr == r_ra || 32'(r_steps) >= MAX_CELLS)
                                 ? S_FB_RD : S_FA_CW;
            S_FB_RD:   n_state = S_FB_WT;
            S_FB_WT:   n_state = (p_rd == r_ptr || 32'(r_steps) >= MAX_CELLS)
                                 ? S_FB_CW : S_FB_RD;
            S_FB_CW:   n_state = S_FB_CP;
            S_FB_CP:   n_state = (r_ptr == r_rb || 32'(r_steps) >= MAX_CELLS)
                                 ? ((r_ra == r_rb) ? S_WA_RD : S_RK_RD) : S_FB_CW;
            S_RK_RD:   n_state = S_RK_WT;
            S_RK_WT:   n_state = S_LINK;
            S_LINK:    n_state = S_WA_RD;
            S_WA_RD:   n_state = S_WA_WT;
            S_WA_WT:   n_state = S_WB_RD;
            S_WB_RD:   n_state = S_WB_WT;
            S_WB_WT:   n_state = S_WR_WALL;
            S_WR_WALL: n_state = S_OUT;
            S_OUT:     if (!i_stall) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // memory control
    logic [WALL_W-1:0] a_clear_mask, b_clear_mask;
    always_comb begin
        a_clear_mask = '0;
        b_clear_mask = '0;
        if (r_merged) begin
            case (r_dir)
                DIR_LEFT:  begin a_clear_mask = W_LEFT;   b_clear_mask = W_RIGHT;  end
                DIR_RIGHT: begin a_clear_mask = W_RIGHT;  b_clear_mask = W_LEFT;   end
                DIR_UP:    begin a_clear_mask = W_TOP;    b_clear_mask = W_BOTTOM; end
                DIR_DOWN:  begin a_clear_mask = W_BOTTOM; b_clear_mask = W_TOP;    end
                default:   ;
            endcase
        end
    end

    always_comb begin
        p_we = 1'b0; k_we = 1'b0; w_we = 1'b0;
        p_addr = r_ptr; k_addr = r_ra; w_addr = a_addr;
        p_wd = r_ra; k_wd = '0; w_wd = '1;
        o_stall = 1'b1;
        o_cfg_ready = (r_state == S_IDLE || r_state == S_CLEAR) && !pending_clear_item;
        unique case (r_state)
            S_CLEAR: begin
                p_we = 1'b1; k_we = 1'b1; w_we = 1'b1;
                p_addr = r_clr; k_addr = r_clr; w_addr = r_clr;
                p_wd = r_clr; k_wd = '0; w_wd = '1;
            end
            S_IDLE:  o_stall = i_new_maze && !pending_clear_item;
            S_FA_CW: begin p_we = 1'b1; p_wd = r_ra; end
            S_FB_CW: begin p_we = 1'b1; p_wd = r_rb; end
            S_RK_RD: k_addr = r_ra;
            S_RK_WT: k_addr = r_rb;
            S_LINK: begin
                if (r_rank_a == k_rd) begin
                    p_addr = r_rb; p_wd = r_ra; p_we = 1'b1;
                    k_addr = r_ra; k_we = (r_rank_a != '1);
                    k_wd = r_rank_a + RANK_W'(1);
                end else if (r_rank_a < k_rd) begin
                    p_addr = r_ra; p_wd = r_rb; p_we = 1'b1;
                end else begin
                    p_addr = r_rb; p_wd = r_ra; p_we = 1'b1;
                end
            end
            S_WA_RD:   w_addr = a_addr;
            S_WB_RD:   w_addr = b_addr;
            S_WR_WALL: begin
                w_addr = a_addr; w_we = 1'b1; w_wd = r_wa & ~a_clear_mask;
            end
            S_OUT: begin
                w_addr = b_addr; w_we = !i_stall && !r_bad && (a_addr != b_addr);
                w_wd = r_wb & ~b_clear_mask;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_columns    <= COL_W'(64);
            r_cell_count <= CNT_W'(4096);
            r_clr        <= '0;
            r_newm       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_COLUMNS:    r_columns    <= i_cfg_data[COL_W-1:0];
                    REG_CELL_COUNT: r_cell_count <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_CLEAR) begin
                r_clr <= (32'(r_clr) == MAX_CELLS - 1) ? '0 : r_clr + AW'(1);
            end
            if (r_state == S_IDLE && i_valid && i_new_maze && !r_newm) begin
                r_newm  <= 1'b1;
            end else if (r_state == S_IDLE && i_valid) begin
                r_newm <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_a <= i_cell_a; r_b <= i_cell_b;
                r_bad <= (SW'(i_cell_a) >= cnt_eff) || (SW'(i_cell_b) >= cnt_eff)
                         || (32'(i_cell_a) >= MAX_CELLS) || (32'(i_cell_b) >= MAX_CELLS);
                r_bit <= 4'(IDX_W - 1); r_rem <= '0; r_which <= 1'b0;
                r_merged <= 1'b0;
            end
            S_DIV: begin
                r_quo <= quo_next;
                r_ptr <= a_addr; r_steps <= '0;
                if (r_bit == '0) begin
                    r_bit <= 4'(IDX_W - 1);
                    r_which <= 1'b1;
                    r_rem <= '0;
                    if (!r_which) begin
                        r_qa <= quo_next;
                        r_ma <= col_next;
                    end else if (r_qa == quo_next && col_next + COL_W'(1) == r_ma) begin
                        r_dir <= DIR_LEFT;
                    end else if (r_qa == quo_next && r_ma + COL_W'(1) == col_next) begin
                        r_dir <= DIR_RIGHT;
                    end else if (r_ma == col_next
                                 && QW'(quo_next) + QW'(1) == QW'(r_qa)) begin
                        r_dir <= DIR_UP;
                    end else if (r_ma == col_next
                                 && QW'(r_qa) + QW'(1) == QW'(quo_next)) begin
                        r_dir <= DIR_DOWN;
                    end else begin
                        r_dir <= DIR_NONE;
                    end
                end else begin
                    r_bit <= r_bit - 4'd1;
                    r_rem <= rem_next;
                end
            end
            S_FA_WT: begin
                if (p_rd == r_ptr || 32'(r_steps) >= MAX_CELLS) begin
                    r_ra <= r_ptr; r_ptr <= a_addr; r_steps <= '0;
                end else begin
                    r_ptr <= p_rd; r_steps <= r_steps + SW'(1);
                end
            end
            S_FA_CP: begin
                if (r_ptr == r_ra || 32'(r_steps) >= MAX_CELLS) begin
                    r_ptr <= b_addr; r_steps <= '0;
                end else begin
                    r_ptr <= p_rd; r_steps <= r_steps + SW'(1);
                end
            end
            S_FB_WT: begin
                if (p_rd == r_ptr || 32'(r_steps) >= MAX_CELLS) begin
                    r_rb <= r_ptr; r_ptr <= b_addr; r_steps <= '0;
                end else begin
                    r_ptr <= p_rd; r_steps <= r_steps + SW'(1);
                end
            end
            S_FB_CP: begin
                r_ptr <= p_rd; r_steps <= r_steps + SW'(1);
            end
            S_RK_WT:   r_rank_a <= k_rd;
            S_LINK:    r_merged <= 1'b1;
            S_WA_WT:   r_wa <= w_rd;
            S_WB_WT:   r_wb <= w_rd;
            S_WR_WALL: if (a_addr == b_addr) r_wb <= r_wa;
            default: ;
        endcase
    end

    // in the compress pass the write happens in CW and the old link is read back in CP
    assign o_valid     = (r_state == S_OUT);
    assign o_merged    = r_merged;
    assign o_direction = r_bad ? DIR_NONE : r_dir;
    assign o_walls_a   = r_bad ? '0 : (r_wa & ~a_clear_mask);
    assign o_walls_b   = r_bad ? '0 : ((a_addr == b_addr) ? (r_wa & ~a_clear_mask)
                                                           : (r_wb & ~b_clear_mask));
    assign o_bad_index = r_bad;

    a_out_only_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == S_OUT) else $error("result outside output state");
    a_bad_not_merged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_index |-> !o_merged) else $error("bad index merged");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> o_stall) else $error("input taken while busy");
endmodule
`default_nettype wire

// File: rtl/ufmc_ram.sv
// generic single-port ram with registered read
`default_nettype none
module ufmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// File: tb/tb_union_find_maze_carver_top.sv
// testbench for the union-find maze carver: directed edges, register extremes, full-range indices, random mazes
`timescale 1ns / 1ps
module tb_union_find_maze_carver_top;
    import ufmc_pkg::*;

    localparam int CELLS      = 4096;
    localparam int COLS_MAX   = 64;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic              merged;
        logic [DIR_W-1:0]  direction;
        logic [WALL_W-1:0] walls_a;
        logic [WALL_W-1:0] walls_b;
        logic              bad_index;
    } t_carve;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic i_cfg_index = 1'b0;
    logic [CNT_W-1:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic [IDX_W-1:0] i_cell_a = '0;
    logic [IDX_W-1:0] i_cell_b = '0;
    logic i_new_maze = 1'b0;
    logic i_stall = 1'b0;
    logic o_cfg_ready, o_stall, o_valid, o_merged, o_bad_index;
    logic [DIR_W-1:0] o_direction;
    logic [WALL_W-1:0] o_walls_a, o_walls_b;

    union_find_maze_carver_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_cell_a(i_cell_a), .i_cell_b(i_cell_b), .i_new_maze(i_new_maze),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_merged(o_merged), .o_direction(o_direction),
        .o_walls_a(o_walls_a), .o_walls_b(o_walls_b), .o_bad_index(o_bad_index)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state
    int unsigned parent_of [CELLS];
    int unsigned rank_of [CELLS];
    logic [WALL_W-1:0] walls_of [CELLS];
    int unsigned grid_cols = 64;
    int unsigned grid_cells = 4096;

    t_carve pending_carves[$];
    int unsigned edges_sent = 0;
    int unsigned mazes_built = 0;
    int unsigned words_checked = 0;
    int unsigned mismatches = 0;
    bit steady = 1'b0;

    task automatic clear_forest();
        for (int i = 0; i < CELLS; i++) begin
            parent_of[i] = i;
            rank_of[i] = 0;
            walls_of[i] = 4'hF;
        end
    endtask

    function automatic int unsigned find_root(int unsigned n);
        int unsigned r, nx;
        r = n;
        while (parent_of[r] != r) r = parent_of[r];
        while (n != r) begin
            nx = parent_of[n];
            parent_of[n] = r;
            n = nx;
        end
        return r;
    endfunction

    task automatic carve_edge(input int unsigned a, input int unsigned b, input bit nm,
                              output t_carve res);
        int unsigned cols, cnt, ra, rb, ca, cb, root_a, root_b;
        logic [DIR_W-1:0] dir;
        res = '0;
        if (nm) clear_forest();
        cols = (grid_cols == 0) ? 1 : (grid_cols > COLS_MAX ? COLS_MAX : grid_cols);
        cnt = (grid_cells > CELLS) ? CELLS : grid_cells;
        if (a >= cnt || b >= cnt) begin
            res.bad_index = 1'b1;
            return;
        end
        ra = a / cols; ca = a % cols;
        rb = b / cols; cb = b % cols;
        dir = DIR_NONE;
        if (ra == rb && cb + 1 == ca) dir = DIR_LEFT;
        else if (ra == rb && ca + 1 == cb) dir = DIR_RIGHT;
        else if (ca == cb && rb + 1 == ra) dir = DIR_UP;
        else if (ca == cb && ra + 1 == rb) dir = DIR_DOWN;
        root_a = find_root(a);
        root_b = find_root(b);
        if (root_a != root_b) begin
            res.merged = 1'b1;
            if (rank_of[root_a] == rank_of[root_b]) begin
                parent_of[root_b] = root_a;
                if (rank_of[root_a] < 15) rank_of[root_a]++;
            end else if (rank_of[root_a] < rank_of[root_b]) begin
                parent_of[root_a] = root_b;
            end else begin
                parent_of[root_b] = root_a;
            end
            case (dir)
                DIR_LEFT: begin
                    walls_of[a] &= ~W_LEFT;
                    walls_of[b] &= ~W_RIGHT;
                end
                DIR_RIGHT: begin
                    walls_of[a] &= ~W_RIGHT;
                    walls_of[b] &= ~W_LEFT;
                end
                DIR_UP: begin
                    walls_of[a] &= ~W_TOP;
                    walls_of[b] &= ~W_BOTTOM;
                end
                DIR_DOWN: begin
                    walls_of[a] &= ~W_BOTTOM;
                    walls_of[b] &= ~W_TOP;
                end
                default: ;
            endcase
        end
        res.direction = dir;
        res.walls_a = walls_of[a];
        res.walls_b = walls_of[b];
    endtask

    // present one edge word and hold it until taken; valid stays high on return
    task automatic send_edge(input int unsigned a, input int unsigned b, input bit nm);
        t_carve res;
        if (!steady && $urandom_range(99) < 38) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cell_a <= a[IDX_W-1:0];
        i_cell_b <= b[IDX_W-1:0];
        i_new_maze <= nm;
        do @(posedge i_clk); while (o_stall);
        carve_edge(a % CELLS, b % CELLS, nm, res);
        pending_carves = {pending_carves, res};
        edges_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_carves.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input int unsigned value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value[CNT_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_COLUMNS) grid_cols = value & 32'h7F;
        else grid_cells = value & 32'h1FFF;
    endtask

    always @(posedge i_clk) begin
        i_stall <= !steady && ($urandom_range(99) < 38);
    end

    always @(posedge i_clk) begin
        t_carve got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_merged, o_direction, o_walls_a, o_walls_b, o_bad_index};
            words_checked++;
            if (pending_carves.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %p", got);
            end else begin
                want = pending_carves.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at word %0d: expected %p, got %p",
                                 words_checked, want, got);
                end
            end
        end
    end

    // watchdog on cycles with no handshake on any channel
    int unsigned quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic test_default_grid();
        send_edge(0, 1, 1'b0);
        send_edge(1, 0, 1'b0);
        send_edge(64, 0, 1'b0);
        send_edge(4095, 4094, 1'b0);
        send_edge(4031, 4095, 1'b0);
        send_edge(5, 5, 1'b0);
        send_edge(63, 64, 1'b0);
        send_edge(0, 4095, 1'b0);
        send_edge(2730, 1365, 1'b0);
        send_edge(65, 1, 1'b0);
        send_edge(2, 3, 1'b1);
        send_edge(3, 2, 1'b0);
        drain();
    endtask

    task automatic test_register_extremes();
        write_reg(REG_COLUMNS, 0);
        send_edge(3, 4, 1'b0);
        send_edge(9, 8, 1'b0);
        // single column: first and last row are far apart, not neighbors
        send_edge(0, 4095, 1'b0);
        write_reg(REG_COLUMNS, 127);
        write_reg(REG_CELL_COUNT, 8191);
        send_edge(4095, 4031, 1'b0);
        write_reg(REG_CELL_COUNT, 0);
        send_edge(0, 0, 1'b0);
        write_reg(REG_CELL_COUNT, 5);
        write_reg(REG_COLUMNS, 1);
        send_edge(1, 2, 1'b0);
        send_edge(4, 5, 1'b1);
        send_edge(3, 4, 1'b0);
        send_edge(4095, 0, 1'b0);
        drain();
    endtask

    // full-range indices against the largest grid
    task automatic test_wide_indices(input int n);
        write_reg(REG_COLUMNS, 64);
        write_reg(REG_CELL_COUNT, 4096);
        for (int i = 0; i < n; i++)
            send_edge($urandom_range(4095), $urandom_range(4095), $urandom_range(29) == 0);
        drain();
    endtask

    task automatic test_random_mazes(input int target);
        int unsigned cols, rows, cells, a, b, k;
        int unsigned edge_a[$], edge_b[$];
        while (edges_sent < target) begin
            cols = $urandom_range(1, 8);
            rows = $urandom_range(1, 8);
            cells = cols * rows;
            if ($urandom_range(9) == 0) cols = cols + 128 * $urandom_range(0, 0);
            write_reg(REG_COLUMNS, cols);
            write_reg(REG_CELL_COUNT, cells);
            steady = (mazes_built % 6 == 5);
            edge_a.delete();
            edge_b.delete();
            for (int c = 0; c < cells; c++) begin
                if ((c % cols) + 1 < cols) begin
                    edge_a = {edge_a, c};
                    edge_b = {edge_b, c + 1};
                end
                if (c + cols < cells) begin
                    edge_a = {edge_a, c};
                    edge_b = {edge_b, c + cols};
                end
            end
            edge_a = {edge_a, 0};
            edge_b = {edge_b, 0};
            for (int i = edge_a.size() - 1; i > 0; i--) begin
                k = $urandom_range(i);
                a = edge_a[i]; edge_a[i] = edge_a[k]; edge_a[k] = a;
                b = edge_b[i]; edge_b[i] = edge_b[k]; edge_b[k] = b;
            end
            for (int i = 0; i < edge_a.size(); i++) begin
                a = edge_a[i];
                b = edge_b[i];
                if ($urandom_range(1)) begin
                    k = a; a = b; b = k;
                end
                // occasional noise: arbitrary pairs, some past the grid
                if ($urandom_range(9) == 0) begin
                    a = $urandom_range(cells + 2);
                    b = $urandom_range(cells + 2);
                end
                send_edge(a, b, i == 0);
            end
            mazes_built++;
            steady = 1'b0;
        end
        drain();
    endtask

    initial begin
        clear_forest();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_grid();
        test_register_extremes();
        test_wide_indices(60);
        test_random_mazes(950);
        while (pending_carves.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("sent %0d edges, checked %0d result words over %0d random mazes",
                 edges_sent, words_checked, mazes_built);
        $display("register extremes, bad indices and full-range indices included");
        if (mismatches == 0 && pending_carves.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
